>>> design/oemrt_pkg.sv
// ----------------------------------------------------------------------------
// oemrt_pkg: shared definitions for the ordered route table
// Operation and status codes, default sizes, and the cell control bundle.
// ----------------------------------------------------------------------------
package oemrt_pkg;

  // default sizes
  localparam int TABLE_DEPTH_DEF = 16;
  localparam int KEY_BITS_DEF    = 32;
  localparam int IFACE_BITS_DEF  = 16;

  // operation codes
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic cmp;   // register the key compare
    logic ins;   // shift toward the tail, new entry at the head
    logic del;   // close the gap at and after the first hit
  } cell_ctrl_t;

endpackage

>>> design/oemrt_cell.sv
// ----------------------------------------------------------------------------
// oemrt_cell: one slot of the ordered route table
// Holds one key and interface, compares against the search key, and takes
// its neighbor's entry on insert or delete.
// ----------------------------------------------------------------------------
module oemrt_cell #(
  parameter int KEY_BITS   = oemrt_pkg::KEY_BITS_DEF,
  parameter int IFACE_BITS = oemrt_pkg::IFACE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  oemrt_pkg::cell_ctrl_t  ctrl,
  input  logic                   valid,
  input  logic [KEY_BITS-1:0]    search_key,
  input  logic [KEY_BITS-1:0]    prev_key,
  input  logic [IFACE_BITS-1:0]  prev_iface,
  input  logic [KEY_BITS-1:0]    next_key,
  input  logic [IFACE_BITS-1:0]  next_iface,
  input  logic                   found_in,
  output logic [KEY_BITS-1:0]    key,
  output logic [IFACE_BITS-1:0]  iface,
  output logic                   found_out,
  output logic [IFACE_BITS-1:0]  sel_iface
);

  logic [KEY_BITS-1:0]   key_r;
  logic [IFACE_BITS-1:0] iface_r;
  logic                  match_r;

  // registered compare of this slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else if (ctrl.cmp) begin
      match_r <= valid && (key_r == search_key);
    end
  end

  // slot contents move along the row
  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      key_r   <= prev_key;
      iface_r <= prev_iface;
    end else if (ctrl.del && (found_in || match_r)) begin
      key_r   <= next_key;
      iface_r <= next_iface;
    end
  end

  // first-hit chain and one-hot interface pick
  assign found_out = found_in | match_r;
  assign sel_iface = (match_r && !found_in) ? iface_r : '0;
  assign key       = key_r;
  assign iface     = iface_r;

endmodule

>>> design/ordered_exact_match_route_table_top.sv
// An accepted request is held in the operation register, the key compare is
// registered in every cell in S_CMP, and in S_EXEC the first-hit select, row shift
// and result register write happen, waiting while an earlier result is unread.
// A new request is taken only once the last has left S_EXEC; the output register
// lets the next beat be accepted while a result still waits.
// Reset: synchronous active-low rst_n empties the table and clears handshake
// state; slot contents are not cleared.
// ----------------------------------------------------------------------------
// ordered_exact_match_route_table_top: newest-first exact-match route table
// A row of cells ordered newest to oldest, supporting lookup, add, delete
// and clear over a stream interface.
// ----------------------------------------------------------------------------
module ordered_exact_match_route_table_top #(
  parameter int TABLE_DEPTH = oemrt_pkg::TABLE_DEPTH_DEF,
  parameter int KEY_BITS    = oemrt_pkg::KEY_BITS_DEF,
  parameter int IFACE_BITS  = oemrt_pkg::IFACE_BITS_DEF,
  localparam int IN_W  = ((KEY_BITS + IFACE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((IFACE_BITS + 2 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // route_key, route_iface
  input  logic [1:0]       in_tuser,   // operation
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // result_iface, status
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [1:0]            op_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [IFACE_BITS-1:0] iface_r;
  logic                  out_valid_r;
  logic [OUT_W-1:0]      out_data_r;

  logic                  in_fire;
  logic                  exec_fire;
  logic                  full;
  logic                  hit;
  oemrt_pkg::cell_ctrl_t ctrl;

  logic [KEY_BITS-1:0]   cell_key   [TABLE_DEPTH];
  logic [IFACE_BITS-1:0] cell_iface [TABLE_DEPTH];
  logic [IFACE_BITS-1:0] cell_sel   [TABLE_DEPTH];
  logic [TABLE_DEPTH:0]  found;
  logic [IFACE_BITS-1:0] hit_iface;
  logic [IFACE_BITS-1:0] res_iface;
  logic [1:0]            res_status;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign exec_fire = (state_r == S_EXEC) && (!out_valid_r || out_tready);
  assign full      = (count_r == CNT_W'(TABLE_DEPTH));
  assign hit       = found[TABLE_DEPTH];

  // control broadcast to the row
  always_comb begin
    ctrl.cmp = (state_r == S_CMP);
    ctrl.ins = exec_fire && (op_r == oemrt_pkg::OP_ADD) && !full;
    ctrl.del = exec_fire && (op_r == oemrt_pkg::OP_DELETE) && hit;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_CMP;
      S_CMP:  state_nxt = S_EXEC;
      S_EXEC: if (exec_fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // operation holding register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r    <= in_tuser;
      key_r   <= in_tdata[KEY_BITS-1:0];
      iface_r <= in_tdata[KEY_BITS +: IFACE_BITS];
    end
  end

  // entry count
  always_comb begin
    count_nxt = count_r;
    if (exec_fire) begin
      case (op_r)
        oemrt_pkg::OP_ADD:    if (!full) count_nxt = count_r + CNT_W'(1);
        oemrt_pkg::OP_DELETE: if (hit) count_nxt = count_r - CNT_W'(1);
        oemrt_pkg::OP_CLEAR:  count_nxt = '0;
        default:              count_nxt = count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // row of cells, newest at index 0
  assign found[0] = 1'b0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic [KEY_BITS-1:0]   prev_key;
    logic [IFACE_BITS-1:0] prev_iface;
    logic [KEY_BITS-1:0]   next_key;
    logic [IFACE_BITS-1:0] next_iface;

    if (i == 0) begin : g_head
      assign prev_key   = key_r;
      assign prev_iface = iface_r;
    end else begin : g_body
      assign prev_key   = cell_key[i-1];
      assign prev_iface = cell_iface[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign next_key   = cell_key[i];
      assign next_iface = cell_iface[i];
    end else begin : g_mid
      assign next_key   = cell_key[i+1];
      assign next_iface = cell_iface[i+1];
    end

    oemrt_cell #(
      .KEY_BITS   (KEY_BITS),
      .IFACE_BITS (IFACE_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .valid      (CNT_W'(i) < count_r),
      .search_key (key_r),
      .prev_key   (prev_key),
      .prev_iface (prev_iface),
      .next_key   (next_key),
      .next_iface (next_iface),
      .found_in   (found[i]),
      .key        (cell_key[i]),
      .iface      (cell_iface[i]),
      .found_out  (found[i+1]),
      .sel_iface  (cell_sel[i])
    );
  end

  // merge the one-hot pick of the newest hit
  always_comb begin
    hit_iface = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_iface = hit_iface | cell_sel[i];
    end
  end

  // result fields
  always_comb begin
    res_iface  = '1;
    res_status = oemrt_pkg::ST_OK;
    case (op_r)
      oemrt_pkg::OP_LOOKUP: begin
        if (hit) res_iface = hit_iface;
        else res_status = oemrt_pkg::ST_NOT_FOUND;
      end
      oemrt_pkg::OP_ADD:    if (full) res_status = oemrt_pkg::ST_FULL;
      oemrt_pkg::OP_DELETE: if (!hit) res_status = oemrt_pkg::ST_NOT_FOUND;
      default:              res_status = oemrt_pkg::ST_OK;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_data_r <= OUT_W'({res_status, res_iface});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // table never holds more entries than slots
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // clear empties the table
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    exec_fire && (op_r == oemrt_pkg::OP_CLEAR) |=> count_r == '0)
    else $error("clear left entries");

  // add on a full table reports full and leaves the count alone
  a_add_full: assert property (@(posedge clk) disable iff (!rst_n)
    exec_fire && (op_r == oemrt_pkg::OP_ADD) && full |=>
      (out_data_r[IFACE_BITS +: 2] == oemrt_pkg::ST_FULL) && $stable(count_r))
    else $error("add on full table mishandled");

  // a completed operation always leaves a result beat pending
  a_result_pending: assert property (@(posedge clk) disable iff (!rst_n)
    exec_fire |=> out_valid_r)
    else $error("result beat lost");

endmodule

>>> tb/ordered_exact_match_route_table_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_exact_match_route_table_top_tb: stream test of the route table
// Drives lookup, add, delete and clear beats through the input stream, keeps
// a newest-first shadow table to predict each result beat, and checks every
// result beat in order under several idle and stall mixes, including a long
// receiver hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module ordered_exact_match_route_table_top_tb;

  localparam int DEPTH     = oemrt_pkg::TABLE_DEPTH_DEF;
  localparam int KEY_W     = oemrt_pkg::KEY_BITS_DEF;
  localparam int IFACE_W   = oemrt_pkg::IFACE_BITS_DEF;
  localparam int IN_W      = ((KEY_W + IFACE_W + 7) / 8) * 8;
  localparam int OUT_W     = ((IFACE_W + 2 + 7) / 8) * 8;
  localparam int CYCLE_CAP = 400000;
  localparam int PHASE_LEN = 460;
  localparam int HOLD_LEN  = 300;
  localparam int POOL_SIZE = 8;

  typedef struct packed {
    logic [IFACE_W-1:0] iface;
    logic [1:0]         status;
  } route_result_t;

  // shadow table and ordered store of predicted result beats
  class route_table_scoreboard;
    logic [KEY_W-1:0]   shadow_keys[DEPTH];
    logic [IFACE_W-1:0] shadow_ifaces[DEPTH];
    int                 shadow_count;
    route_result_t      expected_results[$];
    int                 mismatches;

    function new();
      shadow_count = 0;
      mismatches   = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    task report(input string what, input logic [31:0] want, input logic [31:0] got);
      $display("mismatch: %s expected %h got %h", what, want, got);
      mismatches++;
    endtask

    // newest matching slot, or -1
    function int newest_hit(input logic [KEY_W-1:0] key);
      for (int i = 0; i < shadow_count; i++)
        if (shadow_keys[i] == key) return i;
      return -1;
    endfunction

    // apply one accepted request to the shadow table, queue its result
    function void note_request(input logic [1:0] op, input logic [KEY_W-1:0] key,
                               input logic [IFACE_W-1:0] iface);
      route_result_t res;
      int hit;
      res.iface  = '1;
      res.status = oemrt_pkg::ST_OK;
      case (op)
        oemrt_pkg::OP_LOOKUP: begin
          hit = newest_hit(key);
          if (hit >= 0) res.iface = shadow_ifaces[hit];
          else res.status = oemrt_pkg::ST_NOT_FOUND;
        end
        oemrt_pkg::OP_ADD: begin
          if (shadow_count >= DEPTH) begin
            res.status = oemrt_pkg::ST_FULL;
          end else begin
            for (int i = shadow_count; i > 0; i--) begin
              shadow_keys[i]   = shadow_keys[i-1];
              shadow_ifaces[i] = shadow_ifaces[i-1];
            end
            shadow_keys[0]   = key;
            shadow_ifaces[0] = iface;
            shadow_count++;
          end
        end
        oemrt_pkg::OP_DELETE: begin
          hit = newest_hit(key);
          if (hit < 0) begin
            res.status = oemrt_pkg::ST_NOT_FOUND;
          end else begin
            for (int i = hit; i + 1 < shadow_count; i++) begin
              shadow_keys[i]   = shadow_keys[i+1];
              shadow_ifaces[i] = shadow_ifaces[i+1];
            end
            shadow_count--;
          end
        end
        default: shadow_count = 0;
      endcase
      expected_results.push_back(res);
    endfunction

    // compare one result beat against the oldest prediction
    task check_response(input logic [OUT_W-1:0] beat);
      route_result_t want;
      if (expected_results.size() == 0) begin
        report("result beat with nothing pending", '0, 32'(beat));
      end else begin
        want = expected_results.pop_front();
        if (beat[IFACE_W-1:0] !== want.iface)
          report("result_iface", 32'(want.iface), 32'(beat[IFACE_W-1:0]));
        if (beat[IFACE_W+1:IFACE_W] !== want.status)
          report("status", 32'(want.status), 32'(beat[IFACE_W+1:IFACE_W]));
      end
    endtask
  endclass

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata   = '0;   // route_key, route_iface
  logic [1:0]       in_tuser   = oemrt_pkg::OP_LOOKUP;   // operation
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;   // result_iface, status

  int               send_idle  = 0;
  int               recv_stall = 0;
  logic             hold_req   = 1'b0;
  logic             hold_ack   = 1'b0;
  int               hold_left  = 0;
  logic [KEY_W-1:0] key_pool[POOL_SIZE];

  route_table_scoreboard sb = new();

  ordered_exact_match_route_table_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // input beat monitor feeds the predictor
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      sb.note_request(in_tuser, in_tdata[KEY_W-1:0], in_tdata[KEY_W+IFACE_W-1:KEY_W]);
  end

  // result beat monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_response(out_tdata);
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
    end else if (hold_req != hold_ack) begin
      hold_ack   <= hold_req;
      hold_left  <= HOLD_LEN;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // watchdog
  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_CAP) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // one request beat, with an optional random gap ahead of it
  task automatic send_beat(input logic [1:0] op, input logic [KEY_W-1:0] key,
                           input logic [IFACE_W-1:0] iface);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {iface, key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // fresh key pool: extremes plus random keys, so lookups and deletes hit
  task automatic refill_pool();
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom();
  endtask

  // random requests in bursts that fill, drain or mix the table
  task automatic send_random(input int count);
    int mode;
    int r;
    logic [1:0] op;
    logic [KEY_W-1:0] key;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) mode = $urandom_range(2);
      r = $urandom_range(99);
      case (mode)
        0:       op = (r < 3)  ? oemrt_pkg::OP_CLEAR :
                      (r < 70) ? oemrt_pkg::OP_ADD :
                      (r < 88) ? oemrt_pkg::OP_LOOKUP : oemrt_pkg::OP_DELETE;
        1:       op = (r < 2)  ? oemrt_pkg::OP_CLEAR :
                      (r < 20) ? oemrt_pkg::OP_ADD :
                      (r < 55) ? oemrt_pkg::OP_LOOKUP : oemrt_pkg::OP_DELETE;
        default: op = (r < 4)  ? oemrt_pkg::OP_CLEAR :
                      (r < 40) ? oemrt_pkg::OP_ADD :
                      (r < 75) ? oemrt_pkg::OP_LOOKUP : oemrt_pkg::OP_DELETE;
      endcase
      // mostly pooled keys, some fresh ones that miss
      if ($urandom_range(99) < 80) key = key_pool[$urandom_range(POOL_SIZE-1)];
      else key = $urandom();
      send_beat(op, key, IFACE_W'($urandom_range(16'hffff)));
    end
  endtask

  initial begin
    refill_pool();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, extremes, duplicates, misses, clear
    send_beat(oemrt_pkg::OP_LOOKUP, 32'h0000_0000, 16'hffff);   // miss on empty table
    send_beat(oemrt_pkg::OP_DELETE, 32'hffff_ffff, 16'h0000);   // delete on empty table
    send_beat(oemrt_pkg::OP_CLEAR,  32'h1234_5678, 16'h5555);   // clear on empty table
    send_beat(oemrt_pkg::OP_ADD,    32'h0000_0000, 16'h0000);
    send_beat(oemrt_pkg::OP_ADD,    32'hffff_ffff, 16'hffff);
    send_beat(oemrt_pkg::OP_ADD,    32'hffff_ffff, 16'h1234);   // duplicate key
    send_beat(oemrt_pkg::OP_LOOKUP, 32'hffff_ffff, 16'h0000);   // newest duplicate wins
    send_beat(oemrt_pkg::OP_LOOKUP, 32'h0000_0000, 16'haaaa);   // hit with zero iface
    send_beat(oemrt_pkg::OP_DELETE, 32'hffff_ffff, 16'h0000);   // removes newest duplicate
    send_beat(oemrt_pkg::OP_LOOKUP, 32'hffff_ffff, 16'h0000);   // older one, all-ones iface
    send_beat(oemrt_pkg::OP_DELETE, 32'hffff_ffff, 16'h0000);
    send_beat(oemrt_pkg::OP_LOOKUP, 32'hffff_ffff, 16'h0000);   // miss after both deletes
    send_beat(oemrt_pkg::OP_DELETE, 32'hdead_beef, 16'h0000);   // missing key
    send_beat(oemrt_pkg::OP_ADD,    32'haaaa_5555, 16'h5aa5);
    send_beat(oemrt_pkg::OP_CLEAR,  32'h0000_0000, 16'h0000);
    send_beat(oemrt_pkg::OP_LOOKUP, 32'h0000_0000, 16'h0000);   // cleared entries are gone
    send_beat(oemrt_pkg::OP_LOOKUP, 32'haaaa_5555, 16'h0000);

    // phase: no idling
    send_random(PHASE_LEN);

    // long receiver hold-off while the sender keeps offering
    hold_req <= ~hold_req;
    refill_pool();
    send_random(30);

    // phase: sender mostly idle
    send_idle = 82;
    refill_pool();
    send_random(PHASE_LEN);

    // phase: receiver mostly stalled
    send_idle  = 0;
    recv_stall = 82;
    refill_pool();
    send_random(PHASE_LEN);

    // phase: both idle a quarter of the time
    send_idle  = 25;
    recv_stall = 25;
    refill_pool();
    send_random(PHASE_LEN);

    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
